/* hw/rtl/fpsqrt_pkg.sv */
package fpsqrt_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned FRAC_W     = 6;
  localparam logic [FRAC_W-1:0] FRAC_MAX   = 6'd32;
  localparam logic [FRAC_W-1:0] FRAC_RESET = 6'd16;

endpackage

/* hw/rtl/fixed_point_square_root_unit.sv */
// Fixed-point square root unit.
// The input channel (in_valid, in_stall, in_value) takes an unsigned operand.
// The result channel (out_valid, out_stall, out_root) returns the floor of
// the square root of the operand shifted left by the fraction count.
// The fraction count is written through cfg_write_en and cfg_write_data;
// the user must write it only while the unit is idle, as the unit itself
// does not enforce this. Counts above 32 act as 32. One shared compare and
// subtract unit produces one root bit per cycle, starting from the top bit
// pair of the radicand. An item is loaded in ST_IDLE and gets its ITERS
// root bits in ST_RUN, where ITERS is (VALUE_BITS + 33) / 2. From ST_DONE
// it moves into the output register once that register is free.
// in_stall is high whenever an item is being worked on.
// The output register holds a finished item until the receiver takes it.
// A new item is accepted while a result waits there. A second root that
// finishes while the receiver still stalls is held until the output frees.
// Reset clears the handshake state and sets the fraction count to 16.
module fixed_point_square_root_unit
  import fpsqrt_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_write_en,
  input  logic [FRAC_W-1:0]     cfg_write_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DATA_W-1:0]     in_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DATA_W-1:0]     out_root
);

  localparam int unsigned ITERS = (VALUE_BITS + 32 + 1) / 2;
  localparam int unsigned RAD_W = 2 * ITERS;
  localparam int unsigned REM_W = ITERS + 3;
  localparam int unsigned CNT_W = $clog2(ITERS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [FRAC_W-1:0]    frac_r, frac_nxt;
  logic [RAD_W-1:0]     rad_r, rad_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [ITERS-1:0]     root_r, root_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]    out_root_r, out_root_nxt;

  logic [FRAC_W-1:0]    frac_eff;
  logic [REM_W-1:0]     shifted;
  logic [REM_W-1:0]     trial;
  logic [REM_W-1:0]     diff;
  logic                 take_bit;
  logic                 in_accept;
  logic                 out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_root  = out_root_r;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign frac_eff  = (frac_r > FRAC_MAX) ? FRAC_MAX : frac_r;

  assign shifted  = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial    = {1'b0, root_r, 2'b01};
  assign take_bit = (shifted >= trial);
  assign diff     = shifted - trial;

  always_comb begin
    state_nxt     = state_r;
    frac_nxt      = frac_r;
    rad_nxt       = rad_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_root_nxt  = out_root_r;
    if (cfg_write_en) begin
      frac_nxt = cfg_write_data;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          rad_nxt   = RAD_W'(in_value[VALUE_BITS-1:0]) << frac_eff;
          rem_nxt   = '0;
          root_nxt  = '0;
          cnt_nxt   = CNT_W'(ITERS - 1);
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
        if (take_bit) begin
          rem_nxt  = diff;
          root_nxt = {root_r[ITERS-2:0], 1'b1};
        end else begin
          rem_nxt  = shifted;
          root_nxt = {root_r[ITERS-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_root_nxt  = DATA_W'(root_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      frac_r      <= FRAC_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      frac_r      <= frac_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rad_r      <= rad_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    out_root_r <= out_root_nxt;
  end

`ifndef NO_ASSERTIONS
  a_load_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == ST_RUN) && (cnt_r == CNT_W'(ITERS - 1)))
    else $error("accepted item did not start the root sequence");

  a_remainder_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> (rem_r <= {2'b00, root_r, 1'b0}))
    else $error("final remainder exceeds twice the root");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r && $stable(out_root_r))
    else $error("waiting result was overwritten");
`endif

endmodule

/* tb/sv/testbench.sv */
module testbench;
  import fpsqrt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_write_en = 1'b0;
  logic [FRAC_W-1:0] cfg_write_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [DATA_W-1:0] in_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DATA_W-1:0] out_root;

  logic [DATA_W-1:0] operand_queue[$];
  logic [DATA_W-1:0] root_queue[$];
  logic [FRAC_W-1:0] frac_setting = FRAC_RESET;

  int unsigned mismatches = 0;
  int unsigned operands_sent = 0;
  int unsigned roots_checked = 0;
  int unsigned frac_writes = 0;
  int unsigned cycle_count = 0;
  int unsigned in_idle_pct = 0;
  int unsigned out_idle_pct = 0;
  int unsigned in_gap = 0;
  int unsigned stall_left = 0;
  int unsigned in_flight = 0;

  fixed_point_square_root_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_root       (out_root)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [DATA_W-1:0] sqrt_floor_root(input logic [DATA_W-1:0] value,
                                                        input logic [FRAC_W-1:0] frac);
    logic [63:0] rem;
    logic [63:0] acc;
    logic [63:0] bitv;
    int unsigned shift;
    shift = 32'((frac > FRAC_MAX) ? FRAC_MAX : frac);
    rem = {32'b0, value} << shift;
    acc = '0;
    bitv = 64'h1 << 62;
    while (bitv > rem && bitv != 0)
      bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= acc + bitv) begin
        rem = rem - (acc + bitv);
        acc = (acc >> 1) + bitv;
      end else begin
        acc = acc >> 1;
      end
      bitv = bitv >> 2;
    end
    return acc[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] random_operand();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 255);
      1: v = 32'h1 << $urandom_range(0, 31);
      2: v = 32'hFFFF_FFFF - $urandom_range(0, 255);
      3: v = $urandom & ((32'h1 << $urandom_range(1, 31)) - 1);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (operand_queue.size() != 0 || in_flight != 0 || in_valid ||
           root_queue.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_frac(input logic [FRAC_W-1:0] frac);
    wait_idle();
    cfg_write_en <= 1'b1;
    cfg_write_data <= frac;
    frac_setting = frac;
    frac_writes++;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic random_phase(input int unsigned count, input int unsigned in_pct,
                              input int unsigned out_pct);
    in_idle_pct = in_pct;
    out_idle_pct = out_pct;
    repeat (count) operand_queue.push_back(random_operand());
  endtask

  // Driver: presents queued operands, holding each one until it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        root_queue.push_back(sqrt_floor_root(in_value, frac_setting));
        operands_sent++;
        if ($urandom_range(0, 99) < in_idle_pct)
          in_gap = $urandom_range(1, 18);
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (operand_queue.size() > 0) begin
          in_valid <= 1'b1;
          in_value <= operand_queue.pop_front();
          in_flight++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every taken root against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (root_queue.size() == 0) begin
          report_mismatch($sformatf("root %h with no item outstanding", out_root));
        end else begin
          logic [DATA_W-1:0] want;
          want = root_queue.pop_front();
          roots_checked++;
          if (in_flight > 0)
            in_flight--;
          if (out_root !== want)
            report_mismatch($sformatf("root %h, expected %h", out_root, want));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < out_idle_pct) begin
        stall_left = $urandom_range(1, 18) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d roots outstanding", root_queue.size());
      $display("[fixed_point_square_root_unit] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // The reset fraction count is used before any write.
    in_idle_pct = 30;
    out_idle_pct = 30;
    operand_queue.push_back(32'h0000_0000);
    operand_queue.push_back(32'h0000_0001);
    operand_queue.push_back(32'h0000_0002);
    operand_queue.push_back(32'h0000_0003);
    operand_queue.push_back(32'h0001_0000);
    operand_queue.push_back(32'h7FFF_FFFF);
    operand_queue.push_back(32'h8000_0000);
    operand_queue.push_back(32'hFFFF_FFFF);
    operand_queue.push_back(32'hAAAA_5555);

    write_frac(6'd0);
    operand_queue.push_back(32'h0000_0000);
    operand_queue.push_back(32'h0000_0001);
    operand_queue.push_back(32'hFFFF_FFFF);
    operand_queue.push_back(32'h0000_0010);

    write_frac(FRAC_MAX);
    operand_queue.push_back(32'h0000_0001);
    operand_queue.push_back(32'hFFFF_FFFF);
    operand_queue.push_back(32'h5555_AAAA);

    // Counts above the maximum must behave as the maximum.
    write_frac(6'd33);
    operand_queue.push_back(32'hFFFF_FFFF);
    operand_queue.push_back(32'h0000_0000);
    write_frac(6'd63);
    operand_queue.push_back(32'hFFFF_FFFF);
    operand_queue.push_back(32'h0000_0002);
    operand_queue.push_back(32'h1234_5678);

    write_frac(6'd1);
    random_phase(80, 25, 25);
    write_frac(6'd31);
    random_phase(80, 50, 10);
    write_frac(FRAC_RESET);
    random_phase(80, 0, 0);
    write_frac(6'd0);
    random_phase(80, 10, 50);
    write_frac(FRAC_MAX);
    random_phase(80, 30, 30);
    write_frac(6'd63);
    random_phase(80, 20, 20);
    write_frac(FRAC_W'($urandom_range(0, 63)));
    random_phase(80, 40, 40);
    write_frac(FRAC_W'($urandom_range(2, 30)));
    random_phase(80, 15, 35);
    write_frac(FRAC_W'($urandom_range(0, 63)));
    random_phase(60, 0, 0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d operands and checked %0d roots over %0d fraction settings.",
             operands_sent, roots_checked, frac_writes + 1);
    $display("Counts 0, 1, 16, 31, 32 and the clamped 33 and 63 were all exercised.");
    if (mismatches == 0 && root_queue.size() == 0) begin
      $display("[fixed_point_square_root_unit] OK");
    end else begin
      $display("%0d mismatches, %0d roots missing", mismatches, root_queue.size());
      $display("[fixed_point_square_root_unit] ERROR");
    end
    $finish;
  end

endmodule
